// ----- src/htw_pkg.sv -----
// Package for the hashed timing wheel: result kinds, modes and default sizes.
package htw_pkg;
    localparam int SlotCountDefault     = 64;
    localparam int TimerCapacityDefault = 32;
    localparam int TickWidth            = 12;
    localparam int TimeoutWidth         = 31;
    localparam int IdWidth              = 32;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_DELETED   = 3'd2;
    localparam logic [2:0] KIND_NOTFOUND  = 3'd3;
    localparam logic [2:0] KIND_EXPIRED   = 3'd4;
    localparam logic [2:0] KIND_TICKDONE  = 3'd5;
endpackage

// ----- src/hashed_timing_wheel_core.sv -----
// Hashed timing wheel: timer table in one synchronous memory, compacted on every pass.
// Add: a 31-step restoring divider (S_DIV), then one memory write in S_ADDW with the accept.
// Delete and tick: each entry is read in S_RD and checked and written back in S_CHK, and
// each expiring timer also passes S_OUT; an add to a full table is answered from S_IDLE.
// One item is in work at a time; the output register lets the next item be taken early.
// Reset clears the fill count, current slot, id counter and sets the tick length to 1.
module hashed_timing_wheel_core #(
    parameter int TIMER_CAPACITY = htw_pkg::TimerCapacityDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, lowest bit up: mode[1:0], timeout[32:2], target_id[64:33], zero pad
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, lowest bit up: kind[2:0], timer_id[34:3], zero pad
    output logic [39:0] m_tdata,
    output logic        m_tlast
);
    import htw_pkg::*;

    // The slot arithmetic relies on a power-of-two wheel, so its size is fixed.
    localparam int SLOT_COUNT = SlotCountDefault;
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int AW = (TIMER_CAPACITY > 1) ? $clog2(TIMER_CAPACITY) : 1;
    localparam int CW = $clog2(TIMER_CAPACITY + 1);
    localparam int EW = IdWidth + TimeoutWidth + SW;
    localparam logic [CW-1:0] CAP = CW'(TIMER_CAPACITY);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_ADDW, S_RD, S_CHK, S_OUT, S_DONE}
        state_t;

    state_t state_reg;
    logic [1:0] mode_reg;
    logic [TimeoutWidth-1:0] quo_reg;
    logic [TickWidth:0] rem_reg;
    logic [4:0] bit_reg;
    logic [IdWidth-1:0] target_reg;
    logic [TickWidth-1:0] tick_reg;
    logic [CW-1:0] fill_reg, rd_reg, wr_reg;
    logic [SW-1:0] slot_reg;
    logic [IdWidth-1:0] idc_reg;
    logic found_reg;
    logic ovalid_reg, olast_reg;
    logic [2:0] okind_reg;
    logic [IdWidth-1:0] oid_reg;

    logic [EW-1:0] mem [TIMER_CAPACITY];
    logic [EW-1:0] rdata_reg;
    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[rd_reg[AW-1:0]];
    end

    logic [IdWidth-1:0]      e_id;
    logic [TimeoutWidth-1:0] e_rot;
    logic [SW-1:0]           e_slot;
    assign {e_id, e_rot, e_slot} = rdata_reg;

    logic [TickWidth-1:0] divisor;
    assign divisor = (tick_reg == '0) ? TickWidth'(1) : tick_reg;

    logic [TickWidth:0] rem_sh;
    logic               rem_ge;
    assign rem_sh = {rem_reg[TickWidth-1:0], quo_reg[TimeoutWidth-1]};
    assign rem_ge = rem_sh >= {1'b0, divisor};

    logic [TimeoutWidth-1:0] ticks;
    assign ticks = (quo_reg == '0) ? TimeoutWidth'(1) : quo_reg;
    logic [IdWidth-1:0] id_new;
    assign id_new = (idc_reg == '1) ? IdWidth'(1) : idc_reg + IdWidth'(1);

    logic [TimeoutWidth+SW:0] slot_sum;
    assign slot_sum = (TimeoutWidth+SW+1)'(slot_reg) + (TimeoutWidth+SW+1)'(ticks);

    logic in_acc, out_free, hit_del, hit_slot;
    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign hit_del  = (mode_reg == MODE_DELETE) && (e_id == target_reg);
    assign hit_slot = (mode_reg == MODE_TICK) && (e_slot == slot_reg);

    always_comb
    begin
        we    = 1'b0;
        waddr = wr_reg[AW-1:0];
        wdata = rdata_reg;
        if (state_reg == S_ADDW)
        begin
            we    = 1'b1;
            waddr = fill_reg[AW-1:0];
            wdata = {id_new, ticks >> SW, slot_sum[SW-1:0]};
        end
        else if (state_reg == S_CHK && !hit_del && !(hit_slot && e_rot == '0))
        begin
            we = 1'b1;
            if (hit_slot)
            begin
                wdata = {e_id, e_rot - TimeoutWidth'(1), e_slot};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tick_reg   <= TickWidth'(1);
            fill_reg   <= '0;
            slot_reg   <= '0;
            idc_reg    <= '0;
            ovalid_reg <= 1'b0;
            rd_reg     <= '0;
            wr_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                tick_reg <= cfg_data;
            end
            if (ovalid_reg && m_tready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        mode_reg   <= s_tdata[1:0];
                        quo_reg    <= s_tdata[32:2];
                        target_reg <= s_tdata[64:33];
                        rem_reg    <= '0;
                        bit_reg    <= '0;
                        rd_reg     <= '0;
                        wr_reg     <= '0;
                        found_reg  <= 1'b0;
                        unique case (s_tdata[1:0])
                            MODE_ADD:
                            begin
                                if (fill_reg >= CAP)
                                begin
                                    ovalid_reg <= 1'b1;
                                    okind_reg  <= KIND_FULL;
                                    oid_reg    <= '0;
                                    olast_reg  <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_DIV;
                                end
                            end
                            MODE_DELETE, MODE_TICK: state_reg <= S_RD;
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_DIV:
                begin
                    // Restoring division, one quotient bit a cycle.
                    rem_reg <= rem_ge ? rem_sh - {1'b0, divisor} : rem_sh;
                    quo_reg <= {quo_reg[TimeoutWidth-2:0], rem_ge};
                    bit_reg <= bit_reg + 5'd1;
                    if (bit_reg == 5'(TimeoutWidth - 1))
                    begin
                        state_reg <= S_ADDW;
                    end
                end
                S_ADDW:
                begin
                    if (out_free)
                    begin
                        fill_reg   <= fill_reg + CW'(1);
                        idc_reg    <= id_new;
                        ovalid_reg <= 1'b1;
                        okind_reg  <= KIND_ADDED;
                        oid_reg    <= id_new;
                        olast_reg  <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                S_RD:
                begin
                    // The read address is presented here; data is valid in S_CHK.
                    state_reg <= (rd_reg < fill_reg) ? S_CHK : S_DONE;
                end
                S_CHK:
                begin
                    if (hit_slot && e_rot == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        if (hit_del)
                        begin
                            found_reg <= 1'b1;
                        end
                        else
                        begin
                            wr_reg <= wr_reg + CW'(1);
                        end
                        rd_reg    <= rd_reg + CW'(1);
                        state_reg <= S_RD;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        ovalid_reg <= 1'b1;
                        okind_reg  <= KIND_EXPIRED;
                        oid_reg    <= e_id;
                        olast_reg  <= 1'b0;
                        rd_reg     <= rd_reg + CW'(1);
                        state_reg  <= S_RD;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        fill_reg   <= wr_reg;
                        ovalid_reg <= 1'b1;
                        oid_reg    <= '0;
                        olast_reg  <= 1'b1;
                        if (mode_reg == MODE_TICK)
                        begin
                            okind_reg <= KIND_TICKDONE;
                            slot_reg  <= (slot_reg == SW'(SLOT_COUNT - 1)) ? '0
                                         : slot_reg + SW'(1);
                        end
                        else
                        begin
                            okind_reg <= found_reg ? KIND_DELETED : KIND_NOTFOUND;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {5'd0, oid_reg, okind_reg};

    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= CAP)
        else $error("fill count above capacity");
    a_wr_le_rd: assert property (@(posedge clk) disable iff (!rst_n) wr_reg <= rd_reg)
        else $error("compaction write pointer ahead of read pointer");
    a_no_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == S_IDLE)
        else $error("item accepted while busy");
    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && okind_reg == KIND_ADDED) |-> oid_reg != '0)
        else $error("zero id handed out");
endmodule

// ----- dv/hashed_timing_wheel_checker.sv -----
// Checker for the timing wheel: predicts every result from the accepted items and compares.
`timescale 1ns / 1ps

module hashed_timing_wheel_checker
    import htw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [11:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);
    localparam int Slots    = SlotCountDefault;
    localparam int Capacity = TimerCapacityDefault;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic        last;
    } wheel_result_t;

    wheel_result_t  awaited_q[$];
    logic [11:0]    tick_len;
    int             fill;
    logic [31:0]    timer_id_m  [Capacity];
    logic [30:0]    timer_rot_m [Capacity];
    logic [5:0]     timer_slot_m[Capacity];
    logic [5:0]     wheel_pos;
    logic [31:0]    last_id;

    // Applies one accepted item to the wheel model and queues what it produces.
    task automatic advance_wheel(input logic [71:0] item);
        logic [1:0]  mode;
        logic [30:0] timeout;
        logic [31:0] target;
        logic [31:0] ticks;
        logic [31:0] divisor;
        int          kept;
        bit          hit;
        mode    = item[1:0];
        timeout = item[32:2];
        target  = item[64:33];
        kept    = 0;
        hit     = 1'b0;
        case (mode)
            MODE_ADD:
            begin
                if (fill >= Capacity)
                begin
                    awaited_q.push_back('{KIND_FULL, 32'd0, 1'b1});
                end
                else
                begin
                    divisor = (tick_len == 0) ? 32'd1 : {20'd0, tick_len};
                    ticks   = {1'b0, timeout} / divisor;
                    if (ticks == 0)
                    begin
                        ticks = 1;
                    end
                    last_id = (last_id == 32'hFFFF_FFFF) ? 32'd1 : last_id + 32'd1;
                    timer_id_m[fill]   = last_id;
                    timer_slot_m[fill] = 6'((wheel_pos + ticks) % Slots);
                    timer_rot_m[fill]  = 31'(ticks / Slots);
                    fill++;
                    awaited_q.push_back('{KIND_ADDED, last_id, 1'b1});
                end
            end
            MODE_DELETE:
            begin
                for (int i = 0; i < fill; i++)
                begin
                    if (timer_id_m[i] == target)
                    begin
                        hit = 1'b1;
                    end
                    else
                    begin
                        timer_id_m[kept]   = timer_id_m[i];
                        timer_rot_m[kept]  = timer_rot_m[i];
                        timer_slot_m[kept] = timer_slot_m[i];
                        kept++;
                    end
                end
                fill = kept;
                awaited_q.push_back('{hit ? KIND_DELETED : KIND_NOTFOUND, 32'd0, 1'b1});
            end
            MODE_TICK:
            begin
                for (int i = 0; i < fill; i++)
                begin
                    if (timer_slot_m[i] == wheel_pos && timer_rot_m[i] == 0)
                    begin
                        awaited_q.push_back('{KIND_EXPIRED, timer_id_m[i], 1'b0});
                    end
                    else
                    begin
                        timer_id_m[kept]   = timer_id_m[i];
                        timer_rot_m[kept]  = (timer_slot_m[i] == wheel_pos) ?
                                             timer_rot_m[i] - 31'd1 : timer_rot_m[i];
                        timer_slot_m[kept] = timer_slot_m[i];
                        kept++;
                    end
                end
                fill      = kept;
                wheel_pos = 6'((wheel_pos + 1) % Slots);
                awaited_q.push_back('{KIND_TICKDONE, 32'd0, 1'b1});
            end
            default:
            begin
                // The unused mode leaves the wheel alone and produces nothing.
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        wheel_result_t want;
        int            bad;
        bad = 0;
        if (!rst_n)
        begin
            awaited_q.delete();
            tick_len  = 12'd1;
            fill      = 0;
            wheel_pos = '0;
            last_id   = '0;
            errors    <= 0;
            pending   <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d id %0d", m_tdata[2:0], m_tdata[34:3]);
                    bad++;
                end
                else
                begin
                    want = awaited_q.pop_front();
                    if (m_tdata[2:0] !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tdata[2:0]);
                        bad++;
                    end
                    if (m_tdata[34:3] !== want.id)
                    begin
                        $error("timer_id: expected %0d, got %0d", want.id, m_tdata[34:3]);
                        bad++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        bad++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                tick_len = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                advance_wheel(s_tdata);
            end
            errors  <= errors + bad;
            pending <= awaited_q.size();
        end
    end
endmodule

// ----- dv/hashed_timing_wheel_core_tb.sv -----
// Top of the timing wheel testbench: clock, reset, stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module hashed_timing_wheel_core_tb;
    import htw_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    int          errors;
    int          pending;

    bit          quiet;
    bit          long_hold;
    logic [11:0] tick_len;
    logic [31:0] ids_issued;

    hashed_timing_wheel_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    hashed_timing_wheel_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #4ms;
        $display("FAILURE");
        $finish;
    end

    // Output side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offers one item; valid is left high after the handshake until the next negedge.
    task automatic offer(input logic [1:0] mode, input logic [30:0] timeout,
                         input logic [31:0] target);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, target, timeout, mode};
        if (mode == MODE_ADD)
        begin
            ids_issued++;
        end
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        // An unused-mode item yields nothing, so give the core time to finish it.
        repeat (100) @(negedge clk);
    endtask

    task automatic set_tick_len(input logic [11:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        tick_len  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int          pick;
        logic [31:0] step;
        logic [30:0] timeout;
        logic [31:0] target;
        pick    = $urandom_range(0, 99);
        step    = (tick_len == 0) ? 32'd1 : {20'd0, tick_len};
        timeout = 31'($urandom_range(0, step * 150));
        target  = ids_issued - $urandom_range(0, 40);
        if ($urandom_range(0, 9) == 0)
        begin
            timeout = 31'($urandom);
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            timeout = 31'($urandom_range(0, step * 3));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            target = $urandom;
        end
        if (pick < 50)
        begin
            offer(MODE_ADD, timeout, target);
        end
        else if (pick < 85)
        begin
            offer(MODE_TICK, timeout, target);
        end
        else if (pick < 98)
        begin
            offer(MODE_DELETE, timeout, target);
        end
        else
        begin
            offer(2'd3, timeout, target);
        end
    endtask

    initial
    begin
        logic [11:0] phase_len[5];
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        quiet      = 1'b0;
        long_hold  = 1'b0;
        tick_len   = 12'd1;
        ids_issued = '0;
        phase_len  = '{12'd3600, 12'd0, 12'd4095, 12'd7, 12'd1};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_tick_len(12'd1);
        offer(MODE_ADD, 31'd0, 32'd0);
        offer(MODE_ADD, 31'd1, 32'd0);
        offer(MODE_ADD, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        offer(MODE_ADD, 31'd63, 32'd0);
        offer(MODE_ADD, 31'd64, 32'd0);
        offer(MODE_ADD, 31'd130, 32'd0);
        offer(MODE_DELETE, 31'd0, 32'd0);
        offer(MODE_DELETE, 31'd0, 32'hFFFF_FFFF);
        offer(MODE_DELETE, 31'h7FFF_FFFF, 32'd2);
        offer(2'd3, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        repeat (4) offer(MODE_TICK, 31'd0, 32'd0);
        offer(MODE_ADD, 31'd2, 32'd0);
        repeat (3) offer(MODE_TICK, 31'd0, 32'd0);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            set_tick_len(phase_len[p]);
            if (p == 4)
            begin
                quiet = 1'b1;
            end
            for (int n = 0; n < 66; n++)
            begin
                if (p == 0 && n == 10)
                begin
                    long_hold = 1'b1;
                end
                if (p == 1 && n == 30)
                begin
                    drain();
                end
                // Long add runs fill the table so that the full answer gets exercised.
                if (p == 2 && n < 36)
                begin
                    offer(MODE_ADD, 31'($urandom_range(0, 3 * 4095)), 32'd0);
                end
                else
                begin
                    random_item();
                end
            end
            drain();
        end

        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
